[rtl/smf3_pkg.sv]
`timescale 1ns / 1ps
// Types, register indexes and the median-of-nine network for the 3x3
// median filter core; its checker uses the types. No dependencies.
package smf3_pkg;

  localparam int SAMPLE_BITS  = 8;
  localparam int PIX_BITS     = 3 * SAMPLE_BITS;
  localparam int CFG_BITS     = 13;
  localparam int ROW_BITS     = 12;
  localparam int COORD_BITS   = 12;
  localparam int ROW_LIMIT    = 4096;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int MED_STEPS = 19;
  localparam int MED_A [MED_STEPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int MED_B [MED_STEPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [8:0][SAMPLE_BITS-1:0] hood_t;

  typedef struct packed {
    sample_t red_sample;
    sample_t green_sample;
    sample_t blue_sample;
  } pixel_t;

  typedef struct packed {
    sample_t                red_median;
    sample_t                green_median;
    sample_t                blue_median;
    logic [COORD_BITS-1:0]  out_row;
    logic [COORD_BITS-1:0]  out_column;
    logic                   last_of_run;
    logic                   frame_end;
  } result_t;

  function automatic sample_t median9(input hood_t v);
    hood_t   p;
    sample_t t;
    p = v;
    for (int k = 0; k < MED_STEPS; k++) begin
      if (p[MED_A[k]] > p[MED_B[k]]) begin
        t           = p[MED_A[k]];
        p[MED_A[k]] = p[MED_B[k]];
        p[MED_B[k]] = t;
      end
    end
    return p[4];
  endfunction

endpackage

[rtl/square_median_filter_3x3_core.sv]
`timescale 1ns / 1ps
// 3x3 per-channel median filter over an RGB raster stream.
// Depends on smf3_pkg.
//
// Usage: pixels enter in raster order on pixel/pixel_valid/pixel_ready;
// results leave on result/result_valid/result_ready, each tagged with its
// row and column. Results lag one row and one column; the last row and
// column of a frame come out with the pixels that complete them, so one
// pixel request gives 0 to 4 results, last_of_run marking the final one.
// Registers image_width and image_height are written on cfg_write; a write
// restarts the frame at row 0, column 0.
// Throughput: one pixel per clock while each pixel gives at most one
// result and result_ready stays high; the result emitter sends one result
// per clock, so a pixel that gives several results holds the input until all are sent.
// After acceptance a pixel passes the line store read, window update,
// neighborhood select and median registers before result_valid rises.
// Reset clears counters, window and pipeline; line stores are not cleared.
// When the receiver stalls, the output register holds and the pipeline
// fills behind it before pixel_ready drops.
module square_median_filter_3x3_core
  import smf3_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  pixel_t              pixel,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_LINE_WIDTH);
  localparam int LW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMPW = (LW > CFG_BITS) ? LW : CFG_BITS;
  localparam int HW   = CFG_BITS;

  logic [CFG_BITS-1:0] image_width, image_height;
  logic [LW-1:0]       eff_w;
  logic [HW-1:0]       eff_h;

  always_comb begin
    if (image_width == '0) eff_w = LW'(1);
    else if (CMPW'(image_width) > CMPW'(MAX_LINE_WIDTH)) eff_w = LW'(MAX_LINE_WIDTH);
    else eff_w = LW'(image_width);
    if (image_height == '0) eff_h = HW'(1);
    else if (image_height > HW'(ROW_LIMIT)) eff_h = HW'(ROW_LIMIT);
    else eff_h = image_height;
  end

  logic [PIX_BITS-1:0] older_row_store [MAX_LINE_WIDTH];
  logic [PIX_BITS-1:0] newer_row_store [MAX_LINE_WIDTH];
  logic [PIX_BITS-1:0] rd_old, rd_new;
  logic [PIX_BITS-1:0] win [9];

  logic [CW-1:0]       column_counter;
  logic [ROW_BITS-1:0] row_counter;

  logic                s1_valid, s1_bypass, s1_adv, pix_fire;
  logic [CW-1:0]       s1_c;
  logic [ROW_BITS-1:0] s1_r;
  logic [PIX_BITS-1:0] s1_pix, s1_byp_old, s1_byp_new, s1_old, s1_new, pix_in;

  logic                s2_valid, s2_rowsel, s2_colsel, s2_hr1, s2_hc0, s2_hc1;
  logic [CW-1:0]       s2_c;
  logic [ROW_BITS-1:0] s2_r;
  logic                s2_emit, s2_last, col_more, row_more;
  logic                hr0, hr1, hc0, hc1;

  logic                s3_valid, s3_adv, s3_last, s3_fend;
  hood_t               s3_red, s3_green, s3_blue;
  logic [COORD_BITS-1:0] s3_row, s3_col;

  assign pix_in   = {pixel.blue_sample, pixel.green_sample, pixel.red_sample};
  assign pix_fire = pixel_valid && pixel_ready;

  assign s3_adv    = s3_valid && (!result_valid || result_ready);
  assign col_more  = !s2_colsel && s2_hc1;
  assign row_more  = !s2_rowsel && s2_hr1;
  assign s2_last   = !col_more && !row_more;
  assign s2_emit   = s2_valid && (!s3_valid || s3_adv);
  assign s1_adv    = s1_valid && (!s2_valid || (s2_emit && s2_last));
  assign pixel_ready = !s1_valid || s1_adv;

  assign s1_old = s1_bypass ? s1_byp_old : rd_old;
  assign s1_new = s1_bypass ? s1_byp_new : rd_new;

  assign hr0 = (s1_r != '0);
  assign hr1 = ((HW'(s1_r) + HW'(1)) == eff_h);
  assign hc0 = (s1_c != '0);
  assign hc1 = ((LW'(s1_c) + LW'(1)) == eff_w);

  // line stores: read at request, write back when the item enters the window
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      rd_old <= older_row_store[column_counter];
      rd_new <= newer_row_store[column_counter];
    end
    if (s1_adv) begin
      older_row_store[s1_c] <= s1_new;
      newer_row_store[s1_c] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= CFG_BITS'(WIDTH_RESET);
      image_height   <= CFG_BITS'(HEIGHT_RESET);
      column_counter <= '0;
      row_counter    <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= 1'b0;
      if (pix_fire) begin
        s1_valid <= 1'b1;
        if ((LW'(column_counter) + LW'(1)) == eff_w) begin
          column_counter <= '0;
          if ((HW'(row_counter) + HW'(1)) == eff_h) row_counter <= '0;
          else row_counter <= row_counter + 1'b1;
        end else begin
          column_counter <= column_counter + 1'b1;
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) image_width <= cfg_data;
        else image_height <= cfg_data;
        column_counter <= '0;
        row_counter    <= '0;
      end
    end
  end

  // stage 1 payload; forward the write-back that lands on the same entry
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s1_c       <= column_counter;
      s1_r       <= row_counter;
      s1_pix     <= pix_in;
      s1_bypass  <= s1_adv && (s1_c == column_counter);
      s1_byp_old <= s1_new;
      s1_byp_new <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (cfg_write) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < 6; i++) win[i] <= win[i+3];
      win[6] <= s1_old;
      win[7] <= s1_new;
      win[8] <= s1_pix;
    end
  end

  // stage 2: walk the target rows and columns of the item in the window
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= (hr0 || hr1) && (hc0 || hc1);
    end else if (s2_emit && s2_last) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_r      <= s1_r;
      s2_c      <= s1_c;
      s2_hr1    <= hr1;
      s2_hc0    <= hc0;
      s2_hc1    <= hc1;
      s2_rowsel <= !hr0;
      s2_colsel <= !hc0;
    end else if (s2_emit && !s2_last) begin
      if (col_more) begin
        s2_colsel <= 1'b1;
      end else begin
        s2_rowsel <= 1'b1;
        s2_colsel <= !s2_hc0;
      end
    end
  end

  logic [ROW_BITS-1:0] tr;
  logic [CW-1:0]       tc;
  logic [1:0]          dr, dc;
  logic [1:0]          rsel [3];
  logic [1:0]          csel [3];
  logic                row_bottom, col_right;
  hood_t               sel_red, sel_green, sel_blue;

  always_comb begin
    logic [PIX_BITS-1:0] nb;
    tr = s2_rowsel ? s2_r : (s2_r - 1'b1);
    dr = s2_rowsel ? 2'd2 : 2'd1;
    tc = s2_colsel ? s2_c : (s2_c - 1'b1);
    dc = s2_colsel ? 2'd2 : 2'd1;
    row_bottom = ((HW'(tr) + HW'(1)) == eff_h);
    col_right  = ((LW'(tc) + LW'(1)) == eff_w);
    rsel[0] = (tr == '0) ? dr : (dr - 2'd1);
    rsel[1] = dr;
    rsel[2] = row_bottom ? dr : (dr + 2'd1);
    csel[0] = (tc == '0) ? dc : (dc - 2'd1);
    csel[1] = dc;
    csel[2] = col_right ? dc : (dc + 2'd1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nb = win[4'(csel[j] * 3 + rsel[i])];
        sel_red[i*3+j]   = nb[SAMPLE_BITS-1:0];
        sel_green[i*3+j] = nb[2*SAMPLE_BITS-1:SAMPLE_BITS];
        sel_blue[i*3+j]  = nb[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      end
    end
  end

  // stage 3: selected neighborhoods
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_emit) begin
      s3_valid <= 1'b1;
    end else if (s3_adv) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_emit) begin
      s3_red   <= sel_red;
      s3_green <= sel_green;
      s3_blue  <= sel_blue;
      s3_row   <= COORD_BITS'(tr);
      s3_col   <= COORD_BITS'(tc);
      s3_last  <= s2_last;
      s3_fend  <= row_bottom && col_right;
    end
  end

  // output register: medians
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      result.red_median   <= median9(s3_red);
      result.green_median <= median9(s3_green);
      result.blue_median  <= median9(s3_blue);
      result.out_row      <= s3_row;
      result.out_column   <= s3_col;
      result.last_of_run  <= s3_last;
      result.frame_end    <= s3_fend;
    end
  end

endmodule

[rtl/smf3_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the 3x3 median filter core, bound into the core module.
// Depends on smf3_pkg and square_median_filter_3x3_core.
module smf3_checker
  import smf3_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    pixel_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) rst |=> pixel_ready)
    else $error("pixel input not ready right after reset");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end |-> result.last_of_run)
    else $error("frame end result not last of its run");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind square_median_filter_3x3_core smf3_checker u_smf3_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_ready  (pixel_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[tb/sv/tb_square_median_filter_3x3_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for square_median_filter_3x3_core: directed and random frames,
// with a scoreboard class that predicts every median result and checks each one in order.
// Depends on smf3_pkg and the core.

module tb_square_median_filter_3x3_core;
  import smf3_pkg::*;

  class median_scoreboard;

    logic [CFG_BITS-1:0] width_reg, height_reg;
    pixel_t              older_row [4096];
    pixel_t              newer_row [4096];
    pixel_t              window [9];
    int unsigned         row_count, col_count;
    result_t             expected_results [$];
    int                  errors;

    function new();
      width_reg  = CFG_BITS'(WIDTH_RESET);
      height_reg = CFG_BITS'(HEIGHT_RESET);
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      row_count = 0;
      col_count = 0;
      for (int i = 0; i < 9; i++) window[i] = '0;
    endfunction

    function void configure(logic idx, logic [CFG_BITS-1:0] value);
      if (idx == REG_WIDTH) width_reg = value;
      else height_reg = value;
      clear_frame();
    endfunction

    function int unsigned clamp_limit(logic [CFG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > ROW_LIMIT) return ROW_LIMIT;
      return v;
    endfunction

    function int unsigned neighbor_slot(int unsigned t, int k, int unsigned lim,
                                        int unsigned d);
      if (k < 0 && t == 0) return d;
      if (k > 0 && t + 1 >= lim) return d;
      return d + k;
    endfunction

    function sample_t channel_of(pixel_t p, int ch);
      case (ch)
        0: return p.red_sample;
        1: return p.green_sample;
        default: return p.blue_sample;
      endcase
    endfunction

    function sample_t middle_of_nine(sample_t v [9]);
      sample_t x;
      int      j;
      for (int i = 1; i < 9; i++) begin
        x = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > x) begin
          v[j + 1] = v[j];
          j--;
        end
        v[j + 1] = x;
      end
      return v[4];
    endfunction

    function result_t neighborhood_median(int unsigned tr, int unsigned dr, int unsigned h,
                                          int unsigned tc, int unsigned dc, int unsigned w);
      result_t     res;
      sample_t     vals [9];
      sample_t     med [3];
      int unsigned rs, cs;
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = -1; i <= 1; i++) begin
          rs = neighbor_slot(tr, i, h, dr);
          for (int j = -1; j <= 1; j++) begin
            cs = neighbor_slot(tc, j, w, dc);
            vals[(i + 1) * 3 + (j + 1)] = channel_of(window[cs * 3 + rs], ch);
          end
        end
        med[ch] = middle_of_nine(vals);
      end
      res.red_median   = med[0];
      res.green_median = med[1];
      res.blue_median  = med[2];
      res.out_row      = COORD_BITS'(tr);
      res.out_column   = COORD_BITS'(tc);
      res.last_of_run  = 1'b0;
      res.frame_end    = (tr + 1 == h && tc + 1 == w);
      return res;
    endfunction

    function void note_pixel(pixel_t pix);
      int unsigned w, h, c, r, nr, nc;
      int unsigned tr [2], tc [2], dr [2], dc [2];
      result_t     batch [$];
      w = clamp_limit(width_reg);
      h = clamp_limit(height_reg);
      c = (col_count >= w) ? 0 : col_count;
      r = (row_count >= h) ? 0 : row_count;
      for (int i = 0; i < 6; i++) window[i] = window[i + 3];
      window[6] = older_row[c];
      window[7] = newer_row[c];
      window[8] = pix;
      older_row[c] = newer_row[c];
      newer_row[c] = pix;
      nr = 0;
      nc = 0;
      if (r >= 1) begin tr[nr] = r - 1; dr[nr] = 1; nr++; end
      if (r + 1 == h) begin tr[nr] = r; dr[nr] = 2; nr++; end
      if (c >= 1) begin tc[nc] = c - 1; dc[nc] = 1; nc++; end
      if (c + 1 == w) begin tc[nc] = c; dc[nc] = 2; nc++; end
      for (int a = 0; a < nr; a++)
        for (int b = 0; b < nc; b++)
          batch.push_back(neighborhood_median(tr[a], dr[a], h, tc[b], dc[b], w));
      if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
      foreach (batch[i]) expected_results.push_back(batch[i]);
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_count = c;
      row_count = r;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, row", got.out_row, -1);
      end else begin
        want = expected_results.pop_front();
        if (got.red_median !== want.red_median)
          report_mismatch("red_median", got.red_median, want.red_median);
        if (got.green_median !== want.green_median)
          report_mismatch("green_median", got.green_median, want.green_median);
        if (got.blue_median !== want.blue_median)
          report_mismatch("blue_median", got.blue_median, want.blue_median);
        if (got.out_row !== want.out_row)
          report_mismatch("out_row", got.out_row, want.out_row);
        if (got.out_column !== want.out_column)
          report_mismatch("out_column", got.out_column, want.out_column);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        if (got.frame_end !== want.frame_end)
          report_mismatch("frame_end", got.frame_end, want.frame_end);
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                pixel_valid;
  logic                pixel_ready;
  pixel_t              pixel;
  logic                result_valid;
  logic                result_ready;
  result_t             result;
  logic                cfg_write;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  median_scoreboard    board;
  bit                  idle_on;
  bit                  long_hold_pending;
  int                  hold_left;
  int                  random_sent;

  square_median_filter_3x3_core dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    board = new();
    idle_on = 1'b1;
    long_hold_pending = 1'b0;
    hold_left = 0;
    random_sent = 0;
  end

  // sample both handshakes with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && pixel_ready) board.note_pixel(pixel);
      if (result_valid && result_ready) board.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_ready <= 1'b0;
      hold_left = $urandom_range(0, 4);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task send_pixel(input pixel_t p);
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task write_reg(input logic idx, input logic [CFG_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.configure(idx, value);
  endtask

  task set_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task send_random(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain();
      send_pixel(pixel_t'(24'($urandom())));
    end
  endtask

  initial begin
    int w, h, frames, phase;
    rst         <= 1'b1;
    pixel_valid <= 1'b0;
    pixel       <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_WIDTH;
    cfg_data    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_size(3, 3);
    for (int k = 0; k < 9; k++)
      send_pixel(k == 0 ? 24'h000000 : k == 8 ? 24'hFFFFFF : k[0] ? 24'hFF00FF : 24'h00FF00);
    set_size(0, 0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hA55A3C);
    set_size(1, 3);
    send_random(3, 1'b0);
    set_size(3, 1);
    send_random(3, 1'b0);
    set_size(2, 2);
    send_random(4, 1'b0);

    set_size(8191, 1);
    long_hold_pending = 1'b1;
    send_random(24, 1'b0);
    set_size(1, 4097);
    send_random(24, 1'b0);

    phase = 0;
    while (random_sent < 280) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 9);
      frames = $urandom_range(1, 3);
      set_size(CFG_BITS'(w), CFG_BITS'(h));
      if (phase == 0) long_hold_pending = 1'b1;
      send_random(w * h * frames, phase == 1);
      random_sent += w * h * frames;
      phase++;
    end
    idle_on = 1'b0;
    set_size(8, 4);
    send_random(64, 1'b0);
    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(8 * 1500000);
    $display("Some tests failed");
    $finish;
  end

endmodule
